FILE: rtl/rrip_pkg.sv
package rrip_pkg;

    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int LEADER_COUNT = 64;
    localparam int SIG_ENTRIES  = 64;

    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int SIG_W    = $clog2(SIG_ENTRIES);
    localparam int ADDR_W   = 48;
    localparam int STRIDE_W = 49;
    localparam int SEL_W    = 10;
    localparam int ROW_W    = 2 * NUM_WAYS;
    localparam int META_W   = ADDR_W + STRIDE_W + 2;

    localparam logic [SEL_W-1:0] SEL_MID = SEL_W'(512);
    localparam logic [SEL_W-1:0] SEL_MAX = SEL_W'(1023);
    localparam logic [1:0]       RRPV_MAX = 2'd3;
    localparam logic [1:0]       RRPV_NEAR = 2'd2;

    typedef enum logic {
        OP_VICTIM = 1'b0,
        OP_UPDATE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [0:0]        opcode;
        logic [10:0]       set_index;
        logic [3:0]        way_index;
        logic [47:0]       phys_addr;
        logic [47:0]       prog_counter;
        logic              was_hit;
    } t_in_item;

    typedef struct packed {
        logic [3:0] victim_way;
        logic [1:0] inserted_rrpv;
        logic       streaming_seen;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic compute;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
    } t_status;

endpackage

FILE: rtl/rrip_ram.sv
module rrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/rrip_ctrl.sv
module rrip_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  rrip_pkg::t_status  i_status,
    output rrip_pkg::t_cmd     o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);
    import rrip_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.compute = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_in_stall  = i_out_stall;
                if (!i_out_stall) begin
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end
endmodule

FILE: rtl/rrip_datapath.sv
module rrip_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrip_pkg::t_cmd      i_cmd,
    input  rrip_pkg::t_in_item  i_in_data,
    output rrip_pkg::t_status   o_status,
    output rrip_pkg::t_out_item o_out_data
);
    import rrip_pkg::*;

    logic [SET_W-1:0]    r_clr_addr;
    logic                r_clr_done;
    t_in_item            r_item;
    logic [SEL_W-1:0]    r_sel;
    t_out_item           r_out;

    logic [ROW_W-1:0]    rrpv_row, rrpv_wdata;
    logic [META_W-1:0]   meta_row, meta_wdata;
    logic                mem_we;
    logic [SET_W-1:0]    mem_waddr, mem_raddr;
    logic [SET_W-1:0]    set_q;
    logic [WAY_W-1:0]    way_q;

    logic [SIG_W-1:0]    sig, sig_raddr, sig_waddr;
    logic [1:0]          sig_cnt, sig_wdata, cnt_n;
    logic                sig_we;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clear_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end
    assign o_status.clear_done = r_clr_done;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    assign set_q     = r_item.set_index[SET_W-1:0];
    assign way_q     = r_item.way_index[WAY_W-1:0];
    assign mem_raddr = i_in_data.set_index[SET_W-1:0];
    assign mem_we    = i_cmd.clear_en || i_cmd.compute;
    assign mem_waddr = i_cmd.clear_en ? r_clr_addr : set_q;

    rrip_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrpv_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(i_cmd.clear_en ? '0 : rrpv_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(rrpv_row)
    );

    rrip_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(i_cmd.clear_en ? '0 : meta_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(meta_row)
    );

    // signature counters, read with the set row
    assign sig_raddr = i_in_data.prog_counter[SIG_W-1:0]
                     ^ i_in_data.prog_counter[2*SIG_W-1:SIG_W];
    assign sig       = r_item.prog_counter[SIG_W-1:0] ^ r_item.prog_counter[2*SIG_W-1:SIG_W];
    assign sig_we    = i_cmd.clear_en ||
                       (i_cmd.compute && t_opcode'(r_item.opcode) == OP_UPDATE);
    assign sig_waddr = i_cmd.clear_en ? r_clr_addr[SIG_W-1:0] : sig;
    assign sig_wdata = i_cmd.clear_en ? 2'd0 : cnt_n;

    rrip_ram #(.WIDTH(2), .DEPTH(SIG_ENTRIES)) u_sig_ram (
        .i_clk  (i_clk),
        .i_we   (sig_we),
        .i_waddr(sig_waddr),
        .i_wdata(sig_wdata),
        .i_raddr(sig_raddr),
        .o_rdata(sig_cnt)
    );

    // stream detector
    logic [ADDR_W-1:0]   prev_addr;
    logic [STRIDE_W-1:0] last_stride, stride;
    logic [1:0]          conf, conf_n;
    logic                steady, streaming;

    always_comb begin
        prev_addr   = meta_row[META_W-1 -: ADDR_W];
        last_stride = meta_row[STRIDE_W+1:2];
        conf        = meta_row[1:0];
        stride      = {1'b0, r_item.phys_addr} - {1'b0, prev_addr};
        steady      = (last_stride != '0) && (stride == last_stride);
        if (steady) begin
            conf_n = (conf == 2'd3) ? conf : conf + 2'd1;
        end else begin
            conf_n = (conf == 2'd0) ? conf : conf - 2'd1;
        end
        streaming  = conf_n[1];
        meta_wdata = {r_item.phys_addr, stride, conf_n};
    end

    // victim select: age and scan
    logic [1:0]       top, lift;
    logic [WAY_W-1:0] victim;
    logic             found;
    logic [ROW_W-1:0] aged_row;

    always_comb begin
        top = '0;
        for (int k = 0; k < NUM_WAYS; k++) begin
            if (rrpv_row[2*k +: 2] > top) top = rrpv_row[2*k +: 2];
        end
        lift     = RRPV_MAX - top;
        victim   = '0;
        found    = 1'b0;
        aged_row = '0;
        for (int k = 0; k < NUM_WAYS; k++) begin
            aged_row[2*k +: 2] = rrpv_row[2*k +: 2] + lift;
            if (!found && rrpv_row[2*k +: 2] == top) begin
                victim = WAY_W'(k);
                found  = 1'b1;
            end
        end
    end

    // update path
    logic             lo_leader, hi_leader, srrip_mode;
    logic [1:0]       ins;
    logic [ROW_W-1:0] upd_row;

    always_comb begin
        if (r_item.was_hit) begin
            cnt_n = (sig_cnt == 2'd3) ? 2'd3 : sig_cnt + 2'd1;
        end else begin
            cnt_n = (sig_cnt == 2'd0) ? 2'd0 : sig_cnt - 2'd1;
        end
        lo_leader  = set_q < SET_W'(LEADER_COUNT);
        hi_leader  = !lo_leader && (set_q >= SET_W'(NUM_SETS - LEADER_COUNT));
        srrip_mode = lo_leader || (!hi_leader && r_sel >= SEL_MID);
        ins = RRPV_MAX;
        if (!streaming && (cnt_n[1] || r_item.was_hit)) begin
            ins = srrip_mode ? RRPV_NEAR : RRPV_MAX;
        end
        upd_row = rrpv_row;
        upd_row[2*way_q +: 2] = ins;
        rrpv_wdata = (t_opcode'(r_item.opcode) == OP_UPDATE) ? upd_row : aged_row;
    end

    // duel selector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= SEL_MID;
        end else if (i_cmd.compute && t_opcode'(r_item.opcode) == OP_UPDATE) begin
            if (r_item.was_hit) begin
                if (lo_leader && r_sel != SEL_MAX) r_sel <= r_sel + 1'b1;
                else if (hi_leader && r_sel != '0) r_sel <= r_sel - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.compute) begin
            r_out.streaming_seen <= streaming;
            if (t_opcode'(r_item.opcode) == OP_UPDATE) begin
                r_out.victim_way    <= '0;
                r_out.inserted_rrpv <= ins;
            end else begin
                r_out.victim_way    <= 4'(victim);
                r_out.inserted_rrpv <= '0;
            end
        end
    end
    assign o_out_data = r_out;
endmodule

FILE: rtl/rrip_ship_stream_replacement_unit.sv
// channel | direction | signals
// in      | to block  | i_in_valid, o_in_stall, i_in_data
// out     | from block| o_out_valid, i_out_stall, o_out_data
//
// for each item the set row is read from the rrpv, metadata and signature
// rams as the item is accepted, then computed and written back in ST_READ
// after reset the block clears all NUM_SETS rows and the signature counters,
// one row per cycle; input stays stalled until the clearing pass is done
// the result is held in an output register until taken; a new item is
// accepted in the same cycle the previous result leaves
module rrip_ship_stream_replacement_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rrip_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrip_pkg::t_out_item o_out_data
);
    import rrip_pkg::*;

    t_cmd    cmd;
    t_status status;

    rrip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid)
    );

    rrip_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in_data (i_in_data),
        .o_status  (status),
        .o_out_data(o_out_data)
    );
endmodule
